// ===== hdl/clp_pkg.sv =====
`timescale 1ns / 1ps

package clp_pkg;

    localparam int T_BITS  = 30;
    localparam int DIV_PER = 2;
    localparam int DIV_STG = T_BITS / DIV_PER;

    localparam logic [2:0] REG_POINT_X  = 3'd0;
    localparam logic [2:0] REG_POINT_Y  = 3'd1;
    localparam logic [2:0] REG_POINT_Z  = 3'd2;
    localparam logic [2:0] REG_NORMAL_X = 3'd3;
    localparam logic [2:0] REG_NORMAL_Y = 3'd4;
    localparam logic [2:0] REG_NORMAL_Z = 3'd5;

    localparam logic [1:0] NI_NONE = 2'd0;
    localparam logic [1:0] NI_ONE  = 2'd1;
    localparam logic [1:0] NI_TWO  = 2'd2;
    localparam logic [1:0] NI_ALL  = 2'd3;

    typedef struct packed {
        logic [2:0][2:0][31:0] v;
        logic [23:0]           color;
        logic [2:0][2:0][32:0] dv;
        logic [2:0][2:0][64:0] pr;
        logic [2:0][65:0]      d;
        logic [1:0]            ni;
        logic [1:0][2:0][32:0] ed;
        logic [1:0][2:0][31:0] vi;
        logic [1:0][66:0]      rem;
        logic [1:0][65:0]      den;
        logic [1:0][T_BITS-1:0] q;
        logic [1:0][2:0][62:0] mp;
        logic [1:0][2:0][31:0] x;
    } clp_item_t;

endpackage

// ===== hdl/triangle_plane_clipper.sv =====
`timescale 1ns / 1ps

// channel   signals                                 accepted when
// input     s_valid s_ready s_a_x..s_c_z s_tri_color   s_valid && s_ready
// output    m_valid m_ready m_out_a_x..m_last_triangle m_valid && m_ready
// config    cfg_we cfg_index cfg_data                 cfg_we
//
// 21 register stages plus an output register
// one triangle enters per cycle while s_ready is high; one that keeps two vertices
// inside holds the output register for two requests, so the output port sets the rate then
// the 30 bit edge fraction comes from a restoring divider, two bits per stage
// synchronous active-low reset clears valid bits and the plane point, and sets the normal to (0, 0, 65536)
// a stall is passed back combinationally along the ready chain, empty stages still fill

module triangle_plane_clipper (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_a_x,
    input  logic signed [31:0] s_a_y,
    input  logic signed [31:0] s_a_z,
    input  logic signed [31:0] s_b_x,
    input  logic signed [31:0] s_b_y,
    input  logic signed [31:0] s_b_z,
    input  logic signed [31:0] s_c_x,
    input  logic signed [31:0] s_c_y,
    input  logic signed [31:0] s_c_z,
    input  logic [23:0]        s_tri_color,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_a_x,
    output logic signed [31:0] m_out_a_y,
    output logic signed [31:0] m_out_a_z,
    output logic signed [31:0] m_out_b_x,
    output logic signed [31:0] m_out_b_y,
    output logic signed [31:0] m_out_b_z,
    output logic signed [31:0] m_out_c_x,
    output logic signed [31:0] m_out_c_y,
    output logic signed [31:0] m_out_c_z,
    output logic [23:0]        m_out_color,
    output logic               m_last_triangle
);

    localparam int ST_DIFF  = 0;
    localparam int ST_PROD  = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_CLASS = 3;
    localparam int ST_DIV0  = 4;
    localparam int ST_MUL   = ST_DIV0 + clp_pkg::DIV_STG;
    localparam int ST_RND   = ST_MUL + 1;
    localparam int NST      = ST_RND + 1;

    logic [2:0][31:0] pt_reg;
    logic [2:0][31:0] nrm_reg;

    clp_pkg::clp_item_t stg_reg  [NST];
    clp_pkg::clp_item_t stg_next [NST];
    logic [NST-1:0]     stg_vld_reg;
    logic [NST-1:0]     stg_in_vld;
    logic [NST:0]       stg_rdy;

    clp_pkg::clp_item_t out_reg;
    logic               m_valid_reg;
    logic               phase_reg;

    // plane registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_reg  <= '0;
            nrm_reg <= {32'd65536, 32'd0, 32'd0};
        end else if (cfg_we) begin
            unique case (cfg_index)
                clp_pkg::REG_POINT_X:  pt_reg[0]  <= cfg_data;
                clp_pkg::REG_POINT_Y:  pt_reg[1]  <= cfg_data;
                clp_pkg::REG_POINT_Z:  pt_reg[2]  <= cfg_data;
                clp_pkg::REG_NORMAL_X: nrm_reg[0] <= cfg_data;
                clp_pkg::REG_NORMAL_Y: nrm_reg[1] <= cfg_data;
                clp_pkg::REG_NORMAL_Z: nrm_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // vertex minus plane point
    always_comb begin
        stg_next[ST_DIFF] = '0;
        stg_next[ST_DIFF].v[0] = {s_a_z, s_a_y, s_a_x};
        stg_next[ST_DIFF].v[1] = {s_b_z, s_b_y, s_b_x};
        stg_next[ST_DIFF].v[2] = {s_c_z, s_c_y, s_c_x};
        stg_next[ST_DIFF].color = s_tri_color;
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                stg_next[ST_DIFF].dv[j][k] =
                    {stg_next[ST_DIFF].v[j][k][31], stg_next[ST_DIFF].v[j][k]}
                    - {pt_reg[k][31], pt_reg[k]};
            end
        end
    end

    always_comb begin
        stg_next[ST_PROD] = stg_reg[ST_PROD-1];
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                stg_next[ST_PROD].pr[j][k] =
                    $signed({{33{nrm_reg[k][31]}}, nrm_reg[k]})
                    * $signed({{32{stg_reg[ST_PROD-1].dv[j][k][32]}},
                               stg_reg[ST_PROD-1].dv[j][k]});
            end
        end
    end

    // signed distance
    always_comb begin
        stg_next[ST_SUM] = stg_reg[ST_SUM-1];
        for (int j = 0; j < 3; j++) begin
            stg_next[ST_SUM].d[j] =
                {stg_reg[ST_SUM-1].pr[j][0][64], stg_reg[ST_SUM-1].pr[j][0]}
                + {stg_reg[ST_SUM-1].pr[j][1][64], stg_reg[ST_SUM-1].pr[j][1]}
                + {stg_reg[ST_SUM-1].pr[j][2][64], stg_reg[ST_SUM-1].pr[j][2]};
        end
    end

    // order inside vertices first, set up both edges
    always_comb begin
        clp_pkg::clp_item_t src;
        logic [2:0]       ins;
        logic [1:0]       cnt;
        logic [2:0][1:0]  ord;
        logic [1:0][1:0]  pi;
        logic [1:0][1:0]  po;
        logic [66:0]      dd;
        src = stg_reg[ST_CLASS-1];
        stg_next[ST_CLASS] = src;
        cnt = 2'd0;
        ord = '0;
        for (int j = 0; j < 3; j++) begin
            ins[j] = !src.d[j][65];
        end
        for (int j = 0; j < 3; j++) begin
            if (ins[j]) begin
                ord[cnt] = 2'(j);
                cnt = cnt + 2'd1;
            end
        end
        stg_next[ST_CLASS].ni = cnt;
        for (int j = 0; j < 3; j++) begin
            if (!ins[j]) begin
                ord[cnt] = 2'(j);
                cnt = cnt + 2'd1;
            end
        end
        for (int m = 0; m < 3; m++) begin
            stg_next[ST_CLASS].v[m] = src.v[ord[m]];
        end
        pi[0] = ord[0];
        po[0] = (stg_next[ST_CLASS].ni == clp_pkg::NI_ONE) ? ord[1] : ord[2];
        pi[1] = (stg_next[ST_CLASS].ni == clp_pkg::NI_ONE) ? ord[0] : ord[1];
        po[1] = ord[2];
        for (int p = 0; p < 2; p++) begin
            stg_next[ST_CLASS].vi[p] = src.v[pi[p]];
            for (int k = 0; k < 3; k++) begin
                stg_next[ST_CLASS].ed[p][k] = {src.v[po[p]][k][31], src.v[po[p]][k]}
                                            - {src.v[pi[p]][k][31], src.v[pi[p]][k]};
            end
            stg_next[ST_CLASS].rem[p] = {1'b0, src.d[pi[p]]};
            dd = {src.d[pi[p]][65], src.d[pi[p]]} - {src.d[po[p]][65], src.d[po[p]]};
            stg_next[ST_CLASS].den[p] = dd[65:0];
            stg_next[ST_CLASS].q[p] = '0;
        end
    end

    // restoring division, DIV_PER fraction bits per stage
    for (genvar g = ST_DIV0; g < ST_MUL; g++) begin : g_div
        always_comb begin
            logic [66:0] r;
            stg_next[g] = stg_reg[g-1];
            for (int s = 0; s < clp_pkg::DIV_PER; s++) begin
                for (int p = 0; p < 2; p++) begin
                    r = {stg_next[g].rem[p][65:0], 1'b0};
                    if (r >= {1'b0, stg_next[g].den[p]}) begin
                        stg_next[g].rem[p] = r - {1'b0, stg_next[g].den[p]};
                        stg_next[g].q[p] = {stg_next[g].q[p][clp_pkg::T_BITS-2:0], 1'b1};
                    end else begin
                        stg_next[g].rem[p] = r;
                        stg_next[g].q[p] = {stg_next[g].q[p][clp_pkg::T_BITS-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_comb begin
        logic signed [63:0] prod;
        stg_next[ST_MUL] = stg_reg[ST_MUL-1];
        for (int p = 0; p < 2; p++) begin
            for (int k = 0; k < 3; k++) begin
                prod = $signed({{31{stg_reg[ST_MUL-1].ed[p][k][32]}},
                                stg_reg[ST_MUL-1].ed[p][k]})
                     * $signed({34'd0, stg_reg[ST_MUL-1].q[p]});
                stg_next[ST_MUL].mp[p][k] = prod[62:0];
            end
        end
    end

    // round to nearest, ties up
    always_comb begin
        logic signed [63:0] sb;
        stg_next[ST_RND] = stg_reg[ST_RND-1];
        for (int p = 0; p < 2; p++) begin
            for (int k = 0; k < 3; k++) begin
                sb = $signed({stg_reg[ST_RND-1].mp[p][k][62], stg_reg[ST_RND-1].mp[p][k]})
                   + 64'sd536870912;
                stg_next[ST_RND].x[p][k] = stg_reg[ST_RND-1].vi[p][k]
                                         + sb[clp_pkg::T_BITS+31:clp_pkg::T_BITS];
            end
        end
    end

    // valid bits and stall chain
    always_comb begin
        stg_in_vld[0] = s_valid;
        for (int k = 1; k < NST; k++) begin
            stg_in_vld[k] = stg_vld_reg[k-1];
        end
        stg_in_vld[ST_CLASS] = stg_vld_reg[ST_CLASS-1]
                             && (stg_next[ST_CLASS].ni != clp_pkg::NI_NONE);
    end

    assign stg_rdy[NST] = !m_valid_reg
                       || (m_ready && (out_reg.ni != clp_pkg::NI_TWO || phase_reg));

    for (genvar g = 0; g < NST; g++) begin : g_stage
        assign stg_rdy[g] = !stg_vld_reg[g] || stg_rdy[g+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_vld_reg[g] <= 1'b0;
            end else if (stg_rdy[g]) begin
                stg_vld_reg[g] <= stg_in_vld[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (stg_rdy[g] && stg_in_vld[g]) begin
                stg_reg[g] <= stg_next[g];
            end
        end
    end

    assign s_ready = stg_rdy[0];

    // output register, two requests for a two-inside triangle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else if (stg_rdy[NST]) begin
            m_valid_reg <= stg_vld_reg[NST-1];
            phase_reg   <= 1'b0;
        end else if (m_ready) begin
            phase_reg   <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_rdy[NST] && stg_vld_reg[NST-1]) begin
            out_reg <= stg_reg[NST-1];
        end
    end

    always_comb begin
        logic [2:0][2:0][31:0] tri_v;
        tri_v = out_reg.v;
        m_last_triangle = 1'b1;
        case (out_reg.ni)
            clp_pkg::NI_ONE: begin
                tri_v[1] = out_reg.x[0];
                tri_v[2] = out_reg.x[1];
            end
            clp_pkg::NI_TWO: begin
                if (phase_reg) begin
                    tri_v[0] = out_reg.v[1];
                    tri_v[1] = out_reg.x[0];
                    tri_v[2] = out_reg.x[1];
                end else begin
                    tri_v[2] = out_reg.x[0];
                    m_last_triangle = 1'b0;
                end
            end
            default: ;
        endcase
        m_out_a_x = tri_v[0][0];
        m_out_a_y = tri_v[0][1];
        m_out_a_z = tri_v[0][2];
        m_out_b_x = tri_v[1][0];
        m_out_b_y = tri_v[1][1];
        m_out_b_z = tri_v[1][2];
        m_out_c_x = tri_v[2][0];
        m_out_c_y = tri_v[2][1];
        m_out_c_z = tri_v[2][2];
    end

    assign m_out_color = out_reg.color;
    assign m_valid     = m_valid_reg;

    a_phase_two: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> (m_valid_reg && out_reg.ni == clp_pkg::NI_TWO))
        else $error("second request without a two-inside triangle");

    a_class_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_vld_reg[ST_CLASS] |-> (stg_reg[ST_CLASS].ni != clp_pkg::NI_NONE))
        else $error("fully clipped triangle kept in pipeline");

    a_phase_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg && m_ready) |=> !phase_reg)
        else $error("second request not retired");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    typedef logic signed [31:0] coord_t;
    typedef coord_t vec3_t [3];

    typedef struct {
        coord_t      v [9];
        logic [23:0] color;
    } tri_req_t;

    typedef struct {
        coord_t      v [9];
        logic [23:0] color;
        logic        last;
    } clip_tri_t;

    class clip_scoreboard;
        coord_t    plane_pt [3];
        coord_t    plane_nrm [3];
        clip_tri_t due_q [$];
        int        errors;
        int        n_tri;
        int        n_out;
        int        n_split;
        int        n_culled;

        function new();
            plane_pt = '{0, 0, 0};
            plane_nrm = '{0, 0, 32'sd65536};
            errors = 0;
            n_tri = 0;
            n_out = 0;
            n_split = 0;
            n_culled = 0;
        endfunction

        function void set_reg(logic [2:0] idx, coord_t val);
            case (idx)
                clp_pkg::REG_POINT_X:  plane_pt[0] = val;
                clp_pkg::REG_POINT_Y:  plane_pt[1] = val;
                clp_pkg::REG_POINT_Z:  plane_pt[2] = val;
                clp_pkg::REG_NORMAL_X: plane_nrm[0] = val;
                clp_pkg::REG_NORMAL_Y: plane_nrm[1] = val;
                clp_pkg::REG_NORMAL_Z: plane_nrm[2] = val;
                default: ;
            endcase
        endfunction

        function logic signed [127:0] plane_dist(coord_t vx, coord_t vy, coord_t vz);
            logic signed [127:0] acc;
            logic signed [127:0] a;
            logic signed [127:0] b;
            coord_t              vv [3];
            acc = 0;
            vv = '{vx, vy, vz};
            for (int k = 0; k < 3; k++) begin
                a = plane_nrm[k];
                b = longint'(vv[k]) - longint'(plane_pt[k]);
                acc = acc + a * b;
            end
            return acc;
        endfunction

        function vec3_t edge_cut(vec3_t vi, logic signed [127:0] di,
                                 vec3_t vo, logic signed [127:0] dout);
            logic signed [127:0] den;
            logic signed [127:0] frac;
            longint              prod;
            longint              step;
            vec3_t               res;
            den = di - dout;
            frac = (di <<< 30) / den;
            for (int k = 0; k < 3; k++) begin
                prod = (longint'(vo[k]) - longint'(vi[k])) * longint'(frac);
                step = (prod + (64'sd1 <<< 29)) >>> 30;
                res[k] = coord_t'(longint'(vi[k]) + step);
            end
            return res;
        endfunction

        function void push_tri(vec3_t p0, vec3_t p1, vec3_t p2, logic [23:0] color,
                               logic last);
            clip_tri_t r;
            for (int k = 0; k < 3; k++) begin
                r.v[k] = p0[k];
                r.v[3 + k] = p1[k];
                r.v[6 + k] = p2[k];
            end
            r.color = color;
            r.last = last;
            due_q.push_back(r);
        endfunction

        function void note_request(tri_req_t t);
            vec3_t               pv [3];
            logic signed [127:0] d [3];
            int                  ins [$];
            int                  outs [$];
            vec3_t               x0;
            vec3_t               x1;
            n_tri++;
            for (int j = 0; j < 3; j++) begin
                pv[j] = '{t.v[3*j], t.v[3*j+1], t.v[3*j+2]};
                d[j] = plane_dist(pv[j][0], pv[j][1], pv[j][2]);
                if (d[j] >= 0) ins.push_back(j);
                else outs.push_back(j);
            end
            case (ins.size())
                0: n_culled++;
                3: push_tri(pv[0], pv[1], pv[2], t.color, 1'b1);
                1: begin
                    x0 = edge_cut(pv[ins[0]], d[ins[0]], pv[outs[0]], d[outs[0]]);
                    x1 = edge_cut(pv[ins[0]], d[ins[0]], pv[outs[1]], d[outs[1]]);
                    push_tri(pv[ins[0]], x0, x1, t.color, 1'b1);
                end
                default: begin
                    n_split++;
                    x0 = edge_cut(pv[ins[0]], d[ins[0]], pv[outs[0]], d[outs[0]]);
                    x1 = edge_cut(pv[ins[1]], d[ins[1]], pv[outs[0]], d[outs[0]]);
                    push_tri(pv[ins[0]], pv[ins[1]], x0, t.color, 1'b0);
                    push_tri(pv[ins[1]], x0, x1, t.color, 1'b1);
                end
            endcase
        endfunction

        function void check_result(clip_tri_t got);
            clip_tri_t want;
            n_out++;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected triangle, color %h", $time, got.color);
                errors++;
                return;
            end
            want = due_q.pop_front();
            for (int k = 0; k < 9; k++)
                if (got.v[k] !== want.v[k]) begin
                    $display("%0t: coord %0d expected %h actual %h", $time, k,
                             want.v[k], got.v[k]);
                    errors++;
                end
            if (got.color !== want.color) begin
                $display("%0t: color expected %h actual %h", $time, want.color, got.color);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    coord_t      s_v [9];
    logic [23:0] s_tri_color;
    logic        m_valid;
    logic        m_ready;
    coord_t      m_v [9];
    logic [23:0] m_out_color;
    logic        m_last_triangle;

    clip_scoreboard sb;
    bit  quiet;
    bit  hold_req;
    int  cycles;

    triangle_plane_clipper u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_x(s_v[0]), .s_a_y(s_v[1]), .s_a_z(s_v[2]),
        .s_b_x(s_v[3]), .s_b_y(s_v[4]), .s_b_z(s_v[5]),
        .s_c_x(s_v[6]), .s_c_y(s_v[7]), .s_c_z(s_v[8]),
        .s_tri_color(s_tri_color),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_a_x(m_v[0]), .m_out_a_y(m_v[1]), .m_out_a_z(m_v[2]),
        .m_out_b_x(m_v[3]), .m_out_b_y(m_v[4]), .m_out_b_z(m_v[5]),
        .m_out_c_x(m_v[6]), .m_out_c_y(m_v[7]), .m_out_c_z(m_v[8]),
        .m_out_color(m_out_color), .m_last_triangle(m_last_triangle)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        clip_tri_t got;
        if (aresetn && m_valid && m_ready) begin
            for (int k = 0; k < 9; k++) got.v[k] = m_v[k];
            got.color = m_out_color;
            got.last = m_last_triangle;
            sb.check_result(got);
        end
    end

    // receiver: random stall bursts, one long hold when asked
    initial begin
        int burst;
        m_ready = 1'b0;
        burst = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_req = 0;
                m_ready <= 1'b1;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 13) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_tri(tri_req_t t);
        @(negedge aclk);
        s_valid <= 1'b1;
        for (int k = 0; k < 9; k++) s_v[k] <= t.v[k];
        s_tri_color <= t.color;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(t);
    endtask

    task automatic sender_gap();
        int n;
        if (quiet || $urandom_range(0, 4) != 0) return;
        n = $urandom_range(1, 13);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, coord_t val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic set_plane(coord_t px, coord_t py, coord_t pz,
                             coord_t nx, coord_t ny, coord_t nz);
        drain();
        write_reg(clp_pkg::REG_POINT_X, px);
        write_reg(clp_pkg::REG_POINT_Y, py);
        write_reg(clp_pkg::REG_POINT_Z, pz);
        write_reg(clp_pkg::REG_NORMAL_X, nx);
        write_reg(clp_pkg::REG_NORMAL_Y, ny);
        write_reg(clp_pkg::REG_NORMAL_Z, nz);
    endtask

    function automatic coord_t rnd_coord();
        case ($urandom_range(0, 9))
            0:       return coord_t'($urandom);
            1:       return coord_t'($urandom_range(0, 2000)) - 1000;
            default: return coord_t'($urandom_range(0, 800000)) - 400000;
        endcase
    endfunction

    function automatic tri_req_t rnd_tri();
        tri_req_t t;
        for (int k = 0; k < 9; k++) t.v[k] = rnd_coord();
        t.color = 24'($urandom);
        return t;
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++) begin
            send_tri(rnd_tri());
            sender_gap();
        end
    endtask

    initial begin
        tri_req_t t;
        sb = new();
        quiet = 0;
        hold_req = 0;
        cycles = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        for (int k = 0; k < 9; k++) s_v[k] = '0;
        s_tri_color = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset plane z = 0, inside is z >= 0: every in/out pattern of the three vertices
        for (int p = 0; p < 8; p++) begin
            t = rnd_tri();
            for (int j = 0; j < 3; j++) t.v[3*j+2] = p[j] ? -32'sd65536 : 32'sd131072;
            send_tri(t);
        end
        // vertex on the plane counts as inside
        t = rnd_tri();
        t.v[2] = 0; t.v[5] = -32'sd5; t.v[8] = 0;
        send_tri(t);
        t.v[2] = 0; t.v[5] = -32'sd5; t.v[8] = -32'sd7;
        send_tri(t);
        // field extremes
        for (int k = 0; k < 9; k++) t.v[k] = 32'sh7fffffff;
        t.color = 24'hffffff;
        send_tri(t);
        for (int k = 0; k < 9; k++) t.v[k] = 32'sh80000000;
        t.color = 24'h000000;
        send_tri(t);
        t.v[2] = 32'sh7fffffff; t.v[5] = 32'sh80000000; t.v[8] = 32'sh80000000;
        send_tri(t);
        t.v[2] = 32'sh7fffffff; t.v[5] = 32'sh7fffffff; t.v[8] = 32'sh80000000;
        send_tri(t);

        // zero normal: everything passes through
        set_plane(32'sd1000, -32'sd1000, 32'sd5, 0, 0, 0);
        for (int i = 0; i < 4; i++) send_tri(rnd_tri());

        set_plane(0, 0, 0, 0, 0, 32'sd65536);
        random_run(130);

        // long output hold while the sender keeps offering
        hold_req = 1;
        random_run(80);

        set_plane(rnd_coord(), rnd_coord(), rnd_coord(),
                  coord_t'($urandom_range(0, 131072)) - 65536,
                  coord_t'($urandom_range(0, 131072)) - 65536,
                  coord_t'($urandom_range(0, 131072)) - 65536);
        random_run(130);

        set_plane(32'sh7fffffff, 32'sh80000000, 0,
                  32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        random_run(100);

        set_plane(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh80000000, 32'sd1);
        random_run(100);

        set_plane(0, 32'sd300000, 0, 0, 32'sh80000000, 0);
        random_run(130);

        set_plane(rnd_coord(), rnd_coord(), rnd_coord(),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        quiet = 1;
        random_run(130);

        drain();
        $display("%0d triangles in, %0d out (%0d split, %0d culled)",
                 sb.n_tri, sb.n_out, sb.n_split, sb.n_culled);
        $display("planes: reset, zero normal, random and extreme point/normal settings");
        if (sb.errors == 0 && sb.due_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
